### sv/gls_pkg.sv
`default_nettype none

package gls_pkg;

    // Field widths fixed by the item format.
    localparam int COORD_W   = 8;
    localparam int CFG_W     = 9;
    localparam int APB_W     = 32;
    localparam int APB_ADDR_W = 3;

    // Depth of the command queue between the front and the back.
    localparam int CMD_DEPTH = 4;
    localparam int CMD_PTR_W = $clog2(CMD_DEPTH);

    // Reset value of both grid size registers.
    localparam logic [CFG_W-1:0] GRID_RESET = 9'd256;

    // Register indexes, decoded from the word address.
    localparam logic REG_GRID_WIDTH  = 1'b0;
    localparam logic REG_GRID_HEIGHT = 1'b1;

    typedef enum logic [1:0] {
        OP_WRITE = 2'd0,
        OP_CLEAR = 2'd1,
        OP_FIRST = 2'd2,
        OP_NONE  = 2'd3
    } t_op;

    // Bresenham error term; holds values between about -510 and +510.
    typedef logic signed [11:0] t_err;

    // One classified command as it travels from the front to the back.
    typedef struct packed {
        logic                 is_write;
        logic                 want_pass;
        logic                 trivial;
        logic                 cell_passable;
        logic [COORD_W-1:0]   x0;
        logic [COORD_W-1:0]   y0;
        logic                 sx_en;
        logic                 sx_neg;
        logic                 sy_en;
        logic                 sy_neg;
        logic                 along_y;
        logic [COORD_W-1:0]   major;
        logic [COORD_W-1:0]   minor;
        t_err                 err0;
    } t_cmd;

    typedef enum logic {
        BS_IDLE,
        BS_WALK
    } t_bstate;

    typedef enum logic [1:0] {
        PH_MAIN,
        PH_CORNER,
        PH_AFTER
    } t_phase;

endpackage

`default_nettype wire

### sv/gls_ram.sv
`default_nettype none

module gls_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // One write port and one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

### sv/gls_front.sv
`default_nettype none

module gls_front (
    input  logic                        i_push,
    input  logic                        i_full,
    input  logic [1:0]                  i_opcode,
    input  logic [gls_pkg::COORD_W-1:0] i_start_x,
    input  logic [gls_pkg::COORD_W-1:0] i_start_y,
    input  logic [gls_pkg::COORD_W-1:0] i_end_x,
    input  logic [gls_pkg::COORD_W-1:0] i_end_y,
    input  logic                        i_cell_passable,
    output logic                        o_cmd_push,
    output gls_pkg::t_cmd               o_cmd
);

    import gls_pkg::*;

    logic               keep;
    logic [COORD_W-1:0] adx;
    logic [COORD_W-1:0] ady;
    logic               swap;

    // Decode the opcode; the unused code is taken and dropped.
    // Then set up the line: step directions, major and minor spans, initial error term.
    always_comb begin
        keep            = 1'b0;
        o_cmd.is_write  = 1'b0;
        o_cmd.want_pass = 1'b0;
        unique case (i_opcode)
            OP_WRITE: begin
                keep           = 1'b1;
                o_cmd.is_write = 1'b1;
            end
            OP_CLEAR: begin
                keep = 1'b1;
            end
            OP_FIRST: begin
                keep            = 1'b1;
                o_cmd.want_pass = 1'b1;
            end
            default: begin
                keep = 1'b0;
            end
        endcase

        adx  = (i_end_x >= i_start_x) ? (i_end_x - i_start_x) : (i_start_x - i_end_x);
        ady  = (i_end_y >= i_start_y) ? (i_end_y - i_start_y) : (i_start_y - i_end_y);
        swap = (ady > adx);

        o_cmd.trivial       = (i_start_x == i_end_x) && (i_start_y == i_end_y);
        o_cmd.cell_passable = i_cell_passable;
        o_cmd.x0            = i_start_x;
        o_cmd.y0            = i_start_y;
        o_cmd.sx_en         = (i_end_x != i_start_x);
        o_cmd.sx_neg        = (i_end_x < i_start_x);
        o_cmd.sy_en         = (i_end_y != i_start_y);
        o_cmd.sy_neg        = (i_end_y < i_start_y);
        o_cmd.along_y       = swap;
        o_cmd.major         = swap ? ady : adx;
        o_cmd.minor         = swap ? adx : ady;
        o_cmd.err0          = $signed({3'b000, o_cmd.minor, 1'b0})
                            - $signed({4'b0000, o_cmd.major});
    end

    assign o_cmd_push = i_push && !i_full && keep;

endmodule

`default_nettype wire

### sv/gls_cmd_fifo.sv
`default_nettype none

module gls_cmd_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  gls_pkg::t_cmd i_cmd,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_empty,
    output gls_pkg::t_cmd o_cmd
);

    import gls_pkg::*;

    t_cmd                 r_mem [CMD_DEPTH];
    logic [CMD_PTR_W-1:0] r_wr;
    logic [CMD_PTR_W-1:0] r_rd;
    logic [CMD_PTR_W:0]   r_cnt;
    logic [CMD_PTR_W:0]   n_cnt;

    assign o_full  = (r_cnt == (CMD_PTR_W+1)'(CMD_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_cmd   = r_mem[r_rd];

    // Occupancy follows the push and pop pair.
    always_comb begin
        case ({i_push, i_pop})
            2'b10:   n_cnt = r_cnt + 1'b1;
            2'b01:   n_cnt = r_cnt - 1'b1;
            default: n_cnt = r_cnt;
        endcase
    end

    // Pointers and count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            r_cnt <= n_cnt;
        end
    end

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

endmodule

`default_nettype wire

### sv/gls_back.sv
`default_nettype none

module gls_back #(
    parameter int GRID_SIDE = 256
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic [gls_pkg::CFG_W-1:0]   i_grid_width,
    input  logic [gls_pkg::CFG_W-1:0]   i_grid_height,
    input  logic                        i_cmd_empty,
    input  gls_pkg::t_cmd               i_cmd,
    output logic                        o_cmd_pop,
    output logic                        o_out_valid,
    input  logic                        i_out_pop,
    output logic                        o_path_clear,
    output logic                        o_hit_found,
    output logic [gls_pkg::COORD_W-1:0] o_hit_x,
    output logic [gls_pkg::COORD_W-1:0] o_hit_y
);

    import gls_pkg::*;

    localparam int CW    = $clog2(GRID_SIDE);
    localparam int AW    = 2 * CW;
    localparam int DEPTH = 1 << AW;

    // Control state.
    t_bstate r_state, n_state;
    logic    r_gen_on, n_gen_on;
    logic    r_chk_valid, n_chk_valid;
    logic    r_out_valid, n_out_valid;

    // Walk state and line setup.
    t_phase             r_phase, n_phase;
    logic [COORD_W-1:0] r_x, n_x;
    logic [COORD_W-1:0] r_y, n_y;
    t_err               r_err, n_err;
    logic [COORD_W-1:0] r_k, n_k;
    logic               r_want, n_want;
    logic               r_along_y, n_along_y;
    logic               r_sx_en, n_sx_en;
    logic               r_sx_neg, n_sx_neg;
    logic               r_sy_en, n_sy_en;
    logic               r_sy_neg, n_sy_neg;
    logic [COORD_W-1:0] r_major, n_major;
    logic [COORD_W-1:0] r_minor, n_minor;

    // Check stage, the cycle after the map read.
    logic [COORD_W-1:0] r_chk_x, n_chk_x;
    logic [COORD_W-1:0] r_chk_y, n_chk_y;
    logic               r_chk_inb, n_chk_inb;
    logic               r_chk_last, n_chk_last;

    // Result register.
    logic               r_out_clear, n_out_clear;
    logic               r_out_found, n_out_found;
    logic [COORD_W-1:0] r_out_hx, n_out_hx;
    logic [COORD_W-1:0] r_out_hy, n_out_hy;

    logic               ram_we;
    logic               ram_re;
    logic [AW-1:0]      ram_waddr;
    logic [AW-1:0]      ram_raddr;
    logic               ram_rdata;
    logic [COORD_W-1:0] probe_x;
    logic [COORD_W-1:0] probe_y;
    logic [COORD_W-1:0] x_step;
    logic [COORD_W-1:0] y_step;
    logic               hit;
    logic               wr_in_store;
    t_err               minor2;
    t_err               major2;

    function automatic logic f_inb(
        input logic [COORD_W-1:0] x,
        input logic [COORD_W-1:0] y,
        input logic [CFG_W-1:0]   w,
        input logic [CFG_W-1:0]   h
    );
        logic ok;
        ok = ({1'b0, x} < w) && ({1'b0, y} < h)
          && (32'(x) < GRID_SIDE) && (32'(y) < GRID_SIDE);
        return ok;
    endfunction

    gls_ram #(
        .WIDTH (1),
        .DEPTH (DEPTH)
    ) u_map (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (i_cmd.cell_passable),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign ram_waddr   = {CW'(i_cmd.y0), CW'(i_cmd.x0)};
    assign ram_raddr   = {CW'(probe_y), CW'(probe_x)};
    assign wr_in_store = (32'(i_cmd.x0) < GRID_SIDE) && (32'(i_cmd.y0) < GRID_SIDE);

    // One step along each axis from the current position.
    assign x_step = r_sx_en ? (r_sx_neg ? r_x - 1'b1 : r_x + 1'b1) : r_x;
    assign y_step = r_sy_en ? (r_sy_neg ? r_y - 1'b1 : r_y + 1'b1) : r_y;
    assign minor2 = $signed({3'b000, r_minor, 1'b0});
    assign major2 = $signed({3'b000, r_major, 1'b0});

    // The checked cell stops the walk when its passability equals the wanted value.
    assign hit = ((r_chk_inb & ram_rdata) == r_want);

    // Sequencer: executes writes, starts queries, issues one map read per cycle.
    always_comb begin
        n_state     = r_state;
        n_gen_on    = r_gen_on;
        n_phase     = r_phase;
        n_x         = r_x;
        n_y         = r_y;
        n_err       = r_err;
        n_k         = r_k;
        n_want      = r_want;
        n_along_y   = r_along_y;
        n_sx_en     = r_sx_en;
        n_sx_neg    = r_sx_neg;
        n_sy_en     = r_sy_en;
        n_sy_neg    = r_sy_neg;
        n_major     = r_major;
        n_minor     = r_minor;
        n_chk_valid = 1'b0;
        n_chk_last  = 1'b0;
        n_out_valid = r_out_valid & ~i_out_pop;
        n_out_clear = r_out_clear;
        n_out_found = r_out_found;
        n_out_hx    = r_out_hx;
        n_out_hy    = r_out_hy;
        o_cmd_pop   = 1'b0;
        ram_we      = 1'b0;
        ram_re      = 1'b0;
        probe_x     = r_x;
        probe_y     = r_y;

        unique case (r_state)
            BS_IDLE: begin
                if (!i_cmd_empty) begin
                    if (i_cmd.is_write) begin
                        o_cmd_pop = 1'b1;
                        ram_we    = wr_in_store;
                    end else if (!r_out_valid) begin
                        o_cmd_pop = 1'b1;
                        if (i_cmd.trivial) begin
                            // Start equal to end: clear, or a hit on the start cell.
                            n_out_valid = 1'b1;
                            n_out_clear = ~i_cmd.want_pass;
                            n_out_found = i_cmd.want_pass;
                            n_out_hx    = i_cmd.want_pass ? i_cmd.x0 : '0;
                            n_out_hy    = i_cmd.want_pass ? i_cmd.y0 : '0;
                        end else begin
                            n_state   = BS_WALK;
                            n_gen_on  = 1'b1;
                            n_phase   = PH_MAIN;
                            n_x       = i_cmd.x0;
                            n_y       = i_cmd.y0;
                            n_err     = i_cmd.err0;
                            n_k       = i_cmd.major;
                            n_want    = i_cmd.want_pass;
                            n_along_y = i_cmd.along_y;
                            n_sx_en   = i_cmd.sx_en;
                            n_sx_neg  = i_cmd.sx_neg;
                            n_sy_en   = i_cmd.sy_en;
                            n_sy_neg  = i_cmd.sy_neg;
                            n_major   = i_cmd.major;
                            n_minor   = i_cmd.minor;
                        end
                    end
                end
            end
            BS_WALK: begin
                // Issue the next probe and advance the line.
                if (r_gen_on) begin
                    ram_re      = 1'b1;
                    n_chk_valid = 1'b1;
                    unique case (r_phase)
                        PH_MAIN: begin
                            if (!r_err[$bits(t_err)-1]) begin
                                n_phase = PH_CORNER;
                            end else begin
                                if (r_along_y) n_y = y_step;
                                else           n_x = x_step;
                                n_err      = r_err + minor2;
                                n_k        = r_k - 1'b1;
                                n_chk_last = (r_k == COORD_W'(1));
                            end
                        end
                        PH_CORNER: begin
                            if (r_along_y) begin
                                probe_y = y_step;
                                n_x     = x_step;
                            end else begin
                                probe_x = x_step;
                                n_y     = y_step;
                            end
                            n_phase = PH_AFTER;
                        end
                        default: begin
                            if (r_along_y) n_y = y_step;
                            else           n_x = x_step;
                            n_err      = r_err - major2 + minor2;
                            n_k        = r_k - 1'b1;
                            n_chk_last = (r_k == COORD_W'(1));
                            n_phase    = PH_MAIN;
                        end
                    endcase
                    if (n_chk_last) begin
                        n_gen_on = 1'b0;
                    end
                end
                // Judge the cell read in the previous cycle.
                if (r_chk_valid && (hit || r_chk_last)) begin
                    n_state     = BS_IDLE;
                    n_gen_on    = 1'b0;
                    n_chk_valid = 1'b0;
                    n_out_valid = 1'b1;
                    n_out_clear = ~r_want & ~hit;
                    n_out_found = r_want & hit;
                    n_out_hx    = (r_want & hit) ? r_chk_x : '0;
                    n_out_hy    = (r_want & hit) ? r_chk_y : '0;
                end
            end
            default: begin
                n_state = BS_IDLE;
            end
        endcase

        n_chk_x   = probe_x;
        n_chk_y   = probe_y;
        n_chk_inb = f_inb(probe_x, probe_y, i_grid_width, i_grid_height);
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BS_IDLE;
            r_gen_on    <= 1'b0;
            r_chk_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_gen_on    <= n_gen_on;
            r_chk_valid <= n_chk_valid;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_phase     <= n_phase;
        r_x         <= n_x;
        r_y         <= n_y;
        r_err       <= n_err;
        r_k         <= n_k;
        r_want      <= n_want;
        r_along_y   <= n_along_y;
        r_sx_en     <= n_sx_en;
        r_sx_neg    <= n_sx_neg;
        r_sy_en     <= n_sy_en;
        r_sy_neg    <= n_sy_neg;
        r_major     <= n_major;
        r_minor     <= n_minor;
        r_chk_x     <= n_chk_x;
        r_chk_y     <= n_chk_y;
        r_chk_inb   <= n_chk_inb;
        r_chk_last  <= n_chk_last;
        r_out_clear <= n_out_clear;
        r_out_found <= n_out_found;
        r_out_hx    <= n_out_hx;
        r_out_hy    <= n_out_hy;
    end

    assign o_out_valid  = r_out_valid;
    assign o_path_clear = r_out_clear;
    assign o_hit_found  = r_out_found;
    assign o_hit_x      = r_out_hx;
    assign o_hit_y      = r_out_hy;

endmodule

`default_nettype wire

### sv/grid_line_of_sight_walker.sv
// Grid line-of-sight walker.
// Items enter through a queue-style port (push, full) and results leave through
// another (empty, pop). Opcode 0 writes one cell of the passable map and gives no
// result; opcodes 1 and 2 are queries that give one result transaction each;
// opcode 3 is taken and dropped. The grid size registers sit on the APB port at
// byte addresses 0 (grid_width) and 4 (grid_height); write them only while idle.
// Up to four items wait in the command queue, so push keeps being accepted while
// a query runs or a result waits.
// A write goes to the map as the back end takes it from the queue. A query holds
// the back end from the cycle that takes it from the queue until its result is set:
// the map has one read port, one cell is read per cycle and judged in the cycle after.
// A line of 255 steps probes up to 765 cells.
// The result shows in the cycle after the last probe is judged.
// Reset empties the queue and the result register and sets both grid size
// registers to 256. The map is not cleared: a cell reads as undefined until it
// has been written. While a result waits unpopped, writes ahead of the next query
// still drain but that query waits; full rises once the queue holds four items.

`default_nettype none

module grid_line_of_sight_walker #(
    parameter int GRID_SIDE = 256
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // Item channel.
    input  logic                           push,
    output logic                           full,
    input  logic [1:0]                     i_opcode,
    input  logic [gls_pkg::COORD_W-1:0]    i_start_x,
    input  logic [gls_pkg::COORD_W-1:0]    i_start_y,
    input  logic [gls_pkg::COORD_W-1:0]    i_end_x,
    input  logic [gls_pkg::COORD_W-1:0]    i_end_y,
    input  logic                           i_cell_passable,
    // Result channel.
    output logic                           empty,
    input  logic                           pop,
    output logic                           o_path_clear,
    output logic                           o_hit_found,
    output logic [gls_pkg::COORD_W-1:0]    o_hit_x,
    output logic [gls_pkg::COORD_W-1:0]    o_hit_y,
    // Configuration port.
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [gls_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [gls_pkg::APB_W-1:0]      pwdata,
    output logic [gls_pkg::APB_W-1:0]      prdata,
    output logic                           pready
);

    import gls_pkg::*;

    logic [CFG_W-1:0] r_grid_width;
    logic [CFG_W-1:0] r_grid_height;
    logic             cfg_we;
    logic             cmd_push;
    t_cmd             cmd_in;
    logic             cmd_pop;
    logic             cmd_empty;
    t_cmd             cmd_out;
    logic             out_valid;

    // Configuration registers.
    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_width  <= GRID_RESET;
            r_grid_height <= GRID_RESET;
        end else if (cfg_we) begin
            unique case (paddr[2])
                REG_GRID_WIDTH:  r_grid_width  <= pwdata[CFG_W-1:0];
                REG_GRID_HEIGHT: r_grid_height <= pwdata[CFG_W-1:0];
                default:         r_grid_width  <= r_grid_width;
            endcase
        end
    end

    // Register read back.
    always_comb begin
        unique case (paddr[2])
            REG_GRID_WIDTH:  prdata = APB_W'(r_grid_width);
            REG_GRID_HEIGHT: prdata = APB_W'(r_grid_height);
            default:         prdata = '0;
        endcase
    end

    gls_front u_front (
        .i_push          (push),
        .i_full          (full),
        .i_opcode        (i_opcode),
        .i_start_x       (i_start_x),
        .i_start_y       (i_start_y),
        .i_end_x         (i_end_x),
        .i_end_y         (i_end_y),
        .i_cell_passable (i_cell_passable),
        .o_cmd_push      (cmd_push),
        .o_cmd           (cmd_in)
    );

    gls_cmd_fifo u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (cmd_push),
        .i_cmd   (cmd_in),
        .o_full  (full),
        .i_pop   (cmd_pop),
        .o_empty (cmd_empty),
        .o_cmd   (cmd_out)
    );

    gls_back #(
        .GRID_SIDE (GRID_SIDE)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_grid_width  (r_grid_width),
        .i_grid_height (r_grid_height),
        .i_cmd_empty   (cmd_empty),
        .i_cmd         (cmd_out),
        .o_cmd_pop     (cmd_pop),
        .o_out_valid   (out_valid),
        .i_out_pop     (pop && out_valid),
        .o_path_clear  (o_path_clear),
        .o_hit_found   (o_hit_found),
        .o_hit_x       (o_hit_x),
        .o_hit_y       (o_hit_y)
    );

    assign empty = !out_valid;

endmodule

`default_nettype wire

### sv/gls_checker.sv
`default_nettype none

module gls_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        pop,
    input logic                        empty,
    input logic                        o_path_clear,
    input logic                        o_hit_found,
    input logic [gls_pkg::COORD_W-1:0] o_hit_x,
    input logic [gls_pkg::COORD_W-1:0] o_hit_y
);

    // Reset leaves no result transaction pending.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> empty)
        else $error("result pending after reset");

    // A waiting result holds until it is popped.
    a_result_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_path_clear) && $stable(o_hit_found)
                              && $stable(o_hit_x) && $stable(o_hit_y)))
        else $error("result changed while stalled");

    // A result belongs to one mode only.
    a_one_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> !(o_path_clear && o_hit_found))
        else $error("both mode flags set");

    // Without a hit the coordinates are zero.
    a_nohit_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !o_hit_found) |-> (o_hit_x == '0 && o_hit_y == '0))
        else $error("coordinates set without a hit");

endmodule

bind grid_line_of_sight_walker gls_checker u_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .pop          (pop),
    .empty        (empty),
    .o_path_clear (o_path_clear),
    .o_hit_found  (o_hit_found),
    .o_hit_x      (o_hit_x),
    .o_hit_y      (o_hit_y)
);

`default_nettype wire

### test/grid_line_of_sight_walker_tb.sv
`timescale 1ns / 1ps

module grid_line_of_sight_walker_tb;
    import gls_pkg::*;

    localparam int SIDE            = 256;
    localparam int CELLS           = SIDE * SIDE;
    localparam int PHASES          = 7;
    localparam int ITEMS_PER_PHASE = 100;
    localparam int SETTLE_CYCLES   = 32;
    localparam int LIMIT_CYCLES    = 3_000_000;

    // Grid sizes used by the random phases, extremes and masked upper bits among them.
    localparam logic [APB_W-1:0] WIDTH_SET [PHASES] = '{
        32'd256, 32'd1, 32'hFFFF_FE25, 32'd0, 32'h0000_FFFF, 32'd256, 32'd200
    };
    localparam logic [APB_W-1:0] HEIGHT_SET [PHASES] = '{
        32'd256, 32'd1, 32'd256, 32'd170, 32'd3, 32'd0, 32'd129
    };

    typedef struct packed {
        logic               path_clear;
        logic               hit_found;
        logic [COORD_W-1:0] hit_x;
        logic [COORD_W-1:0] hit_y;
    } t_sight_result;

    typedef int t_cell_list[$];

    // How the map along a query line is prepared before the query goes out.
    typedef enum int {
        PAINT_FILL,
        PAINT_OPEN,
        PAINT_SHUT
    } t_paint;

    // Scoreboard: mirrors the map and grid size, predicts each query result.
    class sight_scoreboard;
        bit               passable[CELLS];
        logic [CFG_W-1:0] grid_w;
        logic [CFG_W-1:0] grid_h;
        t_sight_result    expected_q[$];
        int               errors;

        function new();
            grid_w = GRID_RESET;
            grid_h = GRID_RESET;
            errors = 0;
        endfunction

        function void set_grid(logic idx, logic [APB_W-1:0] value);
            if (idx == REG_GRID_WIDTH) begin
                grid_w = value[CFG_W-1:0];
            end else begin
                grid_h = value[CFG_W-1:0];
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        // Cells probed by a walk that never stops early, in probe order.
        // Each cell is coded as y * SIDE + x. Start equal to end gives no cells.
        function void line_cells(input int x0, input int y0, input int x1, input int y1,
                                 output t_cell_list cells);
            int x, y, sx, sy, major, minor, err, tmp, k;
            bit along_y;
            cells = {};
            x = x0;
            y = y0;
            sx = (x1 > x0) ? 1 : ((x1 < x0) ? -1 : 0);
            sy = (y1 > y0) ? 1 : ((y1 < y0) ? -1 : 0);
            major = (x1 > x0) ? x1 - x0 : x0 - x1;
            minor = (y1 > y0) ? y1 - y0 : y0 - y1;
            along_y = 1'b0;
            if (minor > major) begin
                tmp = minor;
                minor = major;
                major = tmp;
                along_y = 1'b1;
            end
            err = 2 * minor - major;
            for (k = 1; k <= major; k++) begin
                cells.push_back(y * SIDE + x);
                // A diagonal step also visits the corner cell.
                if (err >= 0) begin
                    if (along_y) begin
                        cells.push_back((y + sy) * SIDE + x);
                        x += sx;
                    end else begin
                        cells.push_back(y * SIDE + x + sx);
                        y += sy;
                    end
                    cells.push_back(y * SIDE + x);
                    err -= 2 * major;
                end
                if (along_y) begin
                    y += sy;
                end else begin
                    x += sx;
                end
                err += 2 * minor;
            end
        endfunction

        function bit cell_open(int c);
            return ((c % SIDE) < int'(grid_w)) && ((c / SIDE) < int'(grid_h)) && passable[c];
        endfunction

        // Called once per accepted input transaction.
        function void note_item(t_op op, int x0, int y0, int x1, int y1, bit pass);
            t_sight_result r;
            t_cell_list cells;
            int i;
            r = '0;
            case (op)
                OP_WRITE: passable[y0 * SIDE + x0] = pass;
                OP_CLEAR: begin
                    r.path_clear = 1'b1;
                    line_cells(x0, y0, x1, y1, cells);
                    for (i = 0; i < cells.size(); i++) begin
                        if (!cell_open(cells[i])) begin
                            r.path_clear = 1'b0;
                            break;
                        end
                    end
                    expected_q.push_back(r);
                end
                OP_FIRST: begin
                    // Start equal to end reports the start cell unconditionally.
                    if (x0 == x1 && y0 == y1) begin
                        r.hit_found = 1'b1;
                        r.hit_x = COORD_W'(x0);
                        r.hit_y = COORD_W'(y0);
                    end else begin
                        line_cells(x0, y0, x1, y1, cells);
                        for (i = 0; i < cells.size(); i++) begin
                            if (cell_open(cells[i])) begin
                                r.hit_found = 1'b1;
                                r.hit_x = COORD_W'(cells[i] % SIDE);
                                r.hit_y = COORD_W'(cells[i] / SIDE);
                                break;
                            end
                        end
                    end
                    expected_q.push_back(r);
                end
                default: ;
            endcase
        endfunction

        // Called once per accepted result transaction.
        function void check_result(t_sight_result got);
            t_sight_result want;
            if (expected_q.size() == 0) begin
                $error("result transaction with no query outstanding");
                errors++;
            end else begin
                want = expected_q.pop_front();
                if (got.path_clear !== want.path_clear) begin
                    $error("path_clear: expected %0d, actual %0d", want.path_clear,
                           got.path_clear);
                    errors++;
                end
                if (got.hit_found !== want.hit_found) begin
                    $error("hit_found: expected %0d, actual %0d", want.hit_found,
                           got.hit_found);
                    errors++;
                end
                if (got.hit_x !== want.hit_x) begin
                    $error("hit_x: expected %0d, actual %0d", want.hit_x, got.hit_x);
                    errors++;
                end
                if (got.hit_y !== want.hit_y) begin
                    $error("hit_y: expected %0d, actual %0d", want.hit_y, got.hit_y);
                    errors++;
                end
            end
        endfunction
    endclass

    logic                  i_clk;
    logic                  i_rst_n         = 1'b0;
    logic                  push            = 1'b0;
    logic                  full;
    logic [1:0]            i_opcode        = '0;
    logic [COORD_W-1:0]    i_start_x       = '0;
    logic [COORD_W-1:0]    i_start_y       = '0;
    logic [COORD_W-1:0]    i_end_x         = '0;
    logic [COORD_W-1:0]    i_end_y         = '0;
    logic                  i_cell_passable = 1'b0;
    logic                  empty;
    logic                  pop             = 1'b0;
    logic                  o_path_clear;
    logic                  o_hit_found;
    logic [COORD_W-1:0]    o_hit_x;
    logic [COORD_W-1:0]    o_hit_y;
    logic                  psel            = 1'b0;
    logic                  penable         = 1'b0;
    logic                  pwrite          = 1'b0;
    logic [APB_ADDR_W-1:0] paddr           = '0;
    logic [APB_W-1:0]      pwdata          = '0;
    logic [APB_W-1:0]      prdata;
    logic                  pready;

    sight_scoreboard sb;
    bit cell_written[CELLS];
    int send_idle;
    int recv_idle;
    int item_count;
    int hot_x;
    int hot_y;

    grid_line_of_sight_walker #(.GRID_SIDE(SIDE)) i_dut (.*);

    // Clock.
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Offer one input transaction, idling beforehand at the current rate.
    task automatic send_item(t_op op, int x0, int y0, int x1, int y1, bit pass);
        if ($urandom_range(0, 99) < send_idle) begin
            push <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(0, 99) < send_idle);
        end
        push <= 1'b1;
        i_opcode <= op;
        i_start_x <= COORD_W'(x0);
        i_start_y <= COORD_W'(y0);
        i_end_x <= COORD_W'(x1);
        i_end_y <= COORD_W'(y1);
        i_cell_passable <= pass;
        do @(posedge i_clk); while (full);
        sb.note_item(op, x0, y0, x1, y1, pass);
        if (op == OP_WRITE) begin
            cell_written[y0 * SIDE + x0] = 1'b1;
        end
        if (op != OP_NONE) begin
            item_count++;
        end
    endtask

    task automatic write_cell(int c, bit pass);
        send_item(OP_WRITE, c % SIDE, c / SIDE, $urandom_range(0, 255),
                  $urandom_range(0, 255), pass);
    endtask

    // Make sure every cell the query may read has been written, and shape the
    // map along the line: open, shut or random fill. An odd cell moves the stop point.
    task automatic prepare_line(int x0, int y0, int x1, int y1, t_paint paint, bit odd_cell);
        t_cell_list cells;
        int fill_pct;
        int i;
        sb.line_cells(x0, y0, x1, y1, cells);
        cells.push_back(y1 * SIDE + x1);
        fill_pct = $urandom_range(0, 100);
        for (i = 0; i < cells.size(); i++) begin
            if (paint == PAINT_OPEN) begin
                write_cell(cells[i], 1'b1);
            end else if (paint == PAINT_SHUT) begin
                write_cell(cells[i], 1'b0);
            end else if (!cell_written[cells[i]]) begin
                write_cell(cells[i], $urandom_range(0, 99) < fill_pct);
            end
        end
        if (odd_cell) begin
            write_cell(cells[$urandom_range(0, cells.size() - 1)], paint == PAINT_SHUT);
        end
    endtask

    task automatic query(t_op op, int x0, int y0, int x1, int y1, t_paint paint, bit odd_cell);
        prepare_line(x0, y0, x1, y1, paint, odd_cell);
        send_item(op, x0, y0, x1, y1, $urandom_range(0, 1));
    endtask

    function automatic int clamp_coord(int v);
        return (v < 0) ? 0 : ((v > SIDE - 1) ? SIDE - 1 : v);
    endfunction

    function automatic int window_origin();
        case ($urandom_range(0, 2))
            0: return 0;
            1: return SIDE - 16;
            default: return $urandom_range(0, SIDE - 16);
        endcase
    endfunction

    // Random query: mostly short lines near a hot window, now and then a long one.
    task automatic random_query();
        int x0, y0, x1, y1, span, r;
        t_op op;
        t_paint paint;
        op = ($urandom_range(0, 1) == 0) ? OP_CLEAR : OP_FIRST;
        if ($urandom_range(0, 3) != 0) begin
            x0 = hot_x + $urandom_range(0, 15);
            y0 = hot_y + $urandom_range(0, 15);
        end else begin
            x0 = $urandom_range(0, SIDE - 1);
            y0 = $urandom_range(0, SIDE - 1);
        end
        r = $urandom_range(0, 79);
        span = (r == 0) ? SIDE - 1 : ((r < 16) ? 16 : 5);
        if ($urandom_range(0, 9) == 0) begin
            x1 = x0;
            y1 = y0;
        end else begin
            x1 = clamp_coord(x0 + int'($urandom_range(0, 2 * span)) - span);
            y1 = clamp_coord(y0 + int'($urandom_range(0, 2 * span)) - span);
        end
        case ($urandom_range(0, 3))
            0: paint = PAINT_OPEN;
            1: paint = PAINT_SHUT;
            default: paint = PAINT_FILL;
        endcase
        query(op, x0, y0, x1, y1, paint, paint != PAINT_FILL && $urandom_range(0, 1) == 1);
    endtask

    // Hold off the sender until every expected result is in, then let queued
    // writes drain through the back end.
    task automatic drain_results();
        push <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // APB write of one grid size register, followed by a read-back.
    task automatic set_grid_reg(logic idx, logic [APB_W-1:0] value);
        logic [APB_W-1:0] want;
        want = APB_W'(value[CFG_W-1:0]);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        sb.set_grid(idx, value);
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata !== want) begin
            $error("prdata: expected %0h, actual %0h", want, prdata);
            sb.errors++;
        end
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    // Result side: pop at random and check each accepted result transaction.
    initial begin
        t_sight_result seen;
        wait (i_rst_n === 1'b1);
        forever begin
            @(posedge i_clk);
            if (pop && !empty) begin
                seen = {o_path_clear, o_hit_found, o_hit_x, o_hit_y};
                sb.check_result(seen);
            end
            pop <= ($urandom_range(0, 99) >= recv_idle);
        end
    end

    // Watchdog.
    initial begin
        int unsigned cycle_count;
        cycle_count = 0;
        while (cycle_count < LIMIT_CYCLES) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("Verification failed");
        $finish;
    end

    // Stimulus and verdict.
    initial begin
        int phase;
        int target;
        int r;
        sb = new();
        send_idle = 30;
        recv_idle = 76;
        item_count = 0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part on the reset grid size.
        query(OP_CLEAR, 5, 5, 5, 5, PAINT_FILL, 1'b0);
        query(OP_FIRST, 255, 0, 255, 0, PAINT_SHUT, 1'b0);
        query(OP_CLEAR, 0, 0, 3, 1, PAINT_OPEN, 1'b0);
        query(OP_FIRST, 255, 255, 252, 253, PAINT_SHUT, 1'b0);
        query(OP_CLEAR, 10, 10, 10, 14, PAINT_FILL, 1'b0);
        query(OP_FIRST, 20, 20, 16, 20, PAINT_FILL, 1'b0);
        query(OP_CLEAR, 30, 30, 33, 33, PAINT_OPEN, 1'b0);
        query(OP_FIRST, 40, 40, 38, 44, PAINT_OPEN, 1'b1);
        query(OP_CLEAR, 200, 200, 197, 201, PAINT_OPEN, 1'b1);
        send_item(OP_NONE, 255, 255, 255, 255, 1'b1);
        write_cell(SIDE * SIDE - 1, 1'b1);
        query(OP_FIRST, 255, 255, 250, 255, PAINT_FILL, 1'b0);
        write_cell(0, 1'b0);
        query(OP_CLEAR, 0, 0, 0, 2, PAINT_FILL, 1'b0);

        // Random phases, each on its own grid size.
        for (phase = 0; phase < PHASES; phase++) begin
            if (phase < 3) begin
                send_idle = 30;
                recv_idle = 76;
            end else if (phase < 6) begin
                send_idle = 76;
                recv_idle = 30;
            end else begin
                send_idle = 0;
                recv_idle = 0;
            end
            drain_results();
            set_grid_reg(REG_GRID_WIDTH, WIDTH_SET[phase]);
            set_grid_reg(REG_GRID_HEIGHT, HEIGHT_SET[phase]);
            hot_x = window_origin();
            hot_y = window_origin();
            target = item_count + ITEMS_PER_PHASE;
            while (item_count < target) begin
                r = $urandom_range(0, 99);
                if (r < 70) begin
                    random_query();
                end else if (r < 95) begin
                    write_cell((hot_y + $urandom_range(0, 15)) * SIDE
                               + hot_x + $urandom_range(0, 15), $urandom_range(0, 1));
                end else begin
                    send_item(OP_NONE, $urandom_range(0, 255), $urandom_range(0, 255),
                              $urandom_range(0, 255), $urandom_range(0, 255),
                              $urandom_range(0, 1));
                end
                if ($urandom_range(0, 149) == 0) begin
                    drain_results();
                end
            end
        end

        drain_results();
        if (sb.errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

### sim.f
sv/gls_pkg.sv
sv/gls_ram.sv
sv/gls_front.sv
sv/gls_cmd_fifo.sv
sv/gls_back.sv
sv/grid_line_of_sight_walker.sv
sv/gls_checker.sv
test/grid_line_of_sight_walker_tb.sv
